### rtl/assert_macros.svh
// Assertion helpers used by the gain command frame handler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define GCFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, off while reset is asserted.
`define GCFH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication, off while reset is asserted.
`define GCFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gcfh_pkg.sv
`default_nettype none

package gcfh_pkg;

  localparam int unsigned FrameLen = 32;
  localparam int unsigned HeadLen  = 16;
  localparam int unsigned NumGains = 6;

  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  pos_t;
  typedef logic [15:0] gain_t;
  typedef gain_t [NumGains-1:0] gain_arr_t;

  // Command frame header and command codes
  localparam byte_t HdrB0    = 8'h8A;
  localparam byte_t HdrB1    = 8'h8B;
  localparam byte_t HdrB2    = 8'h1C;
  localparam byte_t CmdLoad  = 8'hAE;
  localparam byte_t CmdReply = 8'hAD;

  // Reply frame header
  localparam byte_t RepB0 = 8'h88;
  localparam byte_t RepB1 = 8'hAC;
  localparam byte_t RepB2 = 8'h1C;
  localparam byte_t RepB3 = 8'hAD;
  // 8-bit sum of the four reply header bytes
  localparam byte_t RepHdrSum = 8'(RepB0 + RepB1 + RepB2 + RepB3);

  // Positions within a frame
  localparam pos_t PosGainFirst = 5'd4;
  localparam pos_t PosGainLast  = 5'd15;
  localparam pos_t PosLast      = 5'd31;

endpackage

`default_nettype wire

### rtl/gcfh_rx.sv
`default_nettype none

module gcfh_rx (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   beat_i,      // input beat accepted this cycle
  input  wire gcfh_pkg::byte_t  byte_i,
  input  wire                   start_i,
  output gcfh_pkg::gain_arr_t   gains_o,
  output gcfh_pkg::byte_t       csum_o,      // reply checksum for current gains
  output logic                  reply_req_o
);

  gcfh_pkg::pos_t      pos_q, pos_d, pos_eff;
  gcfh_pkg::byte_t     sum_q, sum_d, sum_eff;
  gcfh_pkg::byte_t     gacc_q, gacc_d;
  gcfh_pkg::byte_t     csum_q, csum_d;
  gcfh_pkg::gain_arr_t gains_q, gains_d;
  gcfh_pkg::byte_t     head_q [gcfh_pkg::HeadLen];
  logic                frame_ok;
  logic                at_last;

  // Frame start restarts position and sum before the byte is taken
  assign pos_eff = start_i ? '0 : pos_q;
  assign sum_eff = start_i ? '0 : sum_q;
  assign at_last = (pos_eff == gcfh_pkg::PosLast);

  assign frame_ok = (sum_eff == byte_i) &&
                    (head_q[0] == gcfh_pkg::HdrB0) &&
                    (head_q[1] == gcfh_pkg::HdrB1) &&
                    (head_q[2] == gcfh_pkg::HdrB2);

  assign reply_req_o = beat_i && at_last && frame_ok && (head_q[3] == gcfh_pkg::CmdReply);

  // Next frame state
  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    gacc_d  = gacc_q;
    csum_d  = csum_q;
    gains_d = gains_q;
    if (beat_i) begin
      if (at_last) begin
        pos_d = '0;
        sum_d = '0;
        if (frame_ok && (head_q[3] == gcfh_pkg::CmdLoad)) begin
          for (int i = 0; i < gcfh_pkg::NumGains; i++) begin
            gains_d[i] = {head_q[4 + 2*i], head_q[5 + 2*i]};
          end
          csum_d = 8'(gcfh_pkg::RepHdrSum + gacc_q);
        end
      end else begin
        sum_d = 8'(sum_eff + byte_i);
        pos_d = 5'(pos_eff + 5'd1);
      end
      // Sum the gain bytes as they arrive
      if (pos_eff == '0) begin
        gacc_d = '0;
      end else if ((pos_eff >= gcfh_pkg::PosGainFirst) &&
                   (pos_eff <= gcfh_pkg::PosGainLast)) begin
        gacc_d = 8'(gacc_q + byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      gacc_q  <= '0;
      csum_q  <= gcfh_pkg::RepHdrSum;
      gains_q <= '0;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      gacc_q  <= gacc_d;
      csum_q  <= csum_d;
      gains_q <= gains_d;
    end
  end

  // Capture the frame head
  always_ff @(posedge clk_i) begin
    if (beat_i && !pos_eff[4]) begin
      head_q[pos_eff[3:0]] <= byte_i;
    end
  end

  assign gains_o = gains_q;
  assign csum_o  = csum_q;

endmodule

`default_nettype wire

### rtl/gain_command_frame_handler.sv
// Gain command frame handler. Takes one received byte per beat on the slave
// stream (tuser marks the first byte of a frame) and checks 32-byte command
// frames for header 8A 8B 1C and an additive checksum in byte 31. A load
// command (AE) updates six 16-bit gains; a read command (AD) sends a 32-byte
// reply frame on the master stream with tlast on its checksum byte. Input
// bytes are taken one per cycle, including while the last reply byte waits in
// the output register. After a read command the input is held off until the
// reply sequencer has loaded all 32 reply bytes into the output register, one
// per cycle while the master side does not stall.
`default_nettype none
`include "assert_macros.svh"

module gain_command_frame_handler (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire  [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  wire        s_axis_tuser_i,   // [0] frame_start
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] tx_byte
  output logic       m_axis_tlast_o
);

  logic                in_beat;
  logic                reply_req;
  gcfh_pkg::gain_arr_t gains;
  gcfh_pkg::byte_t     csum;

  logic                rep_active_q, rep_active_d;
  gcfh_pkg::pos_t      rep_idx_q, rep_idx_d;
  logic                rep_load;
  gcfh_pkg::byte_t     rep_byte;
  logic [3:0]          gain_off;

  logic                out_valid_q, out_valid_d;
  gcfh_pkg::byte_t     out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;

  assign s_axis_tready_o = !rep_active_q;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  gcfh_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .byte_i      (s_axis_tdata_i),
    .start_i     (s_axis_tuser_i),
    .gains_o     (gains),
    .csum_o      (csum),
    .reply_req_o (reply_req)
  );

  // Select the reply byte for the current index
  assign gain_off = 4'(rep_idx_q - gcfh_pkg::PosGainFirst);
  always_comb begin
    rep_byte = '0;
    if (rep_idx_q == gcfh_pkg::PosLast) begin
      rep_byte = csum;
    end else if (rep_idx_q > gcfh_pkg::PosGainLast) begin
      rep_byte = '0;
    end else if (rep_idx_q >= gcfh_pkg::PosGainFirst) begin
      rep_byte = gain_off[0] ? gains[gain_off[3:1]][7:0] : gains[gain_off[3:1]][15:8];
    end else begin
      case (rep_idx_q[1:0])
        2'd0:    rep_byte = gcfh_pkg::RepB0;
        2'd1:    rep_byte = gcfh_pkg::RepB1;
        2'd2:    rep_byte = gcfh_pkg::RepB2;
        default: rep_byte = gcfh_pkg::RepB3;
      endcase
    end
  end

  // Advance the reply sequencer when the output register is free
  assign rep_load = rep_active_q && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    rep_active_d = rep_active_q;
    rep_idx_d    = rep_idx_q;
    if (reply_req) begin
      rep_active_d = 1'b1;
      rep_idx_d    = '0;
    end else if (rep_load) begin
      rep_idx_d = 5'(rep_idx_q + 5'd1);
      if (rep_idx_q == gcfh_pkg::PosLast) begin
        rep_active_d = 1'b0;
      end
    end
  end

  // Output register: load a reply byte or drop the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (rep_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = rep_byte;
      out_last_d  = (rep_idx_q == gcfh_pkg::PosLast);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_active_q <= 1'b0;
      rep_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rep_active_q <= rep_active_d;
      rep_idx_q    <= rep_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  // A reply request can only come from an accepted beat, never mid-reply
  `GCFH_ASSERT_IMPL(a_req_idle, reply_req, !rep_active_q, "reply request during reply")
  // Loading the last reply byte ends the reply
  `GCFH_ASSERT_NEXT(a_rep_end, rep_load && (rep_idx_q == gcfh_pkg::PosLast),
                    !rep_active_q && m_axis_tlast_o, "reply did not end on last byte")
  // A new reply starts from the first header byte
  `GCFH_ASSERT_NEXT(a_rep_start, reply_req, rep_active_q && (rep_idx_q == '0),
                    "reply did not start at index zero")

endmodule

`default_nettype wire

### tb/gcfh_reply_checker.sv
`timescale 1ns / 1ps

// Watch both streams of the gain command frame handler, track the frame
// state the block should hold and compare every reply beat with the
// oldest expected one.
module gcfh_reply_checker
  import gcfh_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [7:0]  s_tdata_i,   // [7:0] rx_byte
  input  wire         s_tuser_i,   // [0] frame_start
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [7:0]  m_tdata_i,   // [7:0] tx_byte
  input  wire         m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    byte_t data;
    logic  last;
  } reply_beat_t;

  pos_t        frame_pos;
  byte_t       frame_sum;
  byte_t       head_bytes [HeadLen];
  gain_t       roll_gain  [3];
  gain_t       pitch_gain [3];
  reply_beat_t reply_queue [$];

  initial begin
    frame_pos    = '0;
    frame_sum    = '0;
    fail_count_o = 0;
    pending_o    = 0;
    for (int i = 0; i < HeadLen; i++) head_bytes[i] = '0;
    for (int i = 0; i < 3; i++) begin
      roll_gain[i]  = '0;
      pitch_gain[i] = '0;
    end
  end

  // Build the gain reply frame and queue its 32 beats
  task automatic queue_gain_reply();
    byte_t       reply [FrameLen];
    byte_t       sum;
    reply_beat_t beat;
    for (int i = 0; i < FrameLen; i++) reply[i] = '0;
    reply[0] = RepB0;
    reply[1] = RepB1;
    reply[2] = RepB2;
    reply[3] = RepB3;
    for (int i = 0; i < 3; i++) begin
      reply[4 + 2*i]  = roll_gain[i][15:8];
      reply[5 + 2*i]  = roll_gain[i][7:0];
      reply[10 + 2*i] = pitch_gain[i][15:8];
      reply[11 + 2*i] = pitch_gain[i][7:0];
    end
    sum = '0;
    for (int i = 0; i < HeadLen; i++) sum = sum + reply[i];
    reply[FrameLen-1] = sum;
    for (int i = 0; i < FrameLen; i++) begin
      beat.data = reply[i];
      beat.last = (i == FrameLen - 1);
      reply_queue.push_back(beat);
    end
  endtask

  // Advance the frame state by one received byte
  task automatic absorb_rx_byte(input byte_t rx, input logic start);
    logic frame_ok;
    if (start) begin
      frame_pos = '0;
      frame_sum = '0;
    end
    if (frame_pos < HeadLen) head_bytes[frame_pos[3:0]] = rx;
    if (frame_pos == PosLast) begin
      frame_ok = (frame_sum == rx) && (head_bytes[0] == HdrB0) &&
                 (head_bytes[1] == HdrB1) && (head_bytes[2] == HdrB2);
      if (frame_ok && head_bytes[3] == CmdLoad) begin
        for (int i = 0; i < 3; i++) begin
          roll_gain[i]  = {head_bytes[4 + 2*i], head_bytes[5 + 2*i]};
          pitch_gain[i] = {head_bytes[10 + 2*i], head_bytes[11 + 2*i]};
        end
      end else if (frame_ok && head_bytes[3] == CmdReply) begin
        queue_gain_reply();
      end
      frame_pos = '0;
      frame_sum = '0;
    end else begin
      frame_sum = frame_sum + rx;
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // Take input beats into the prediction, check output beats
  always @(posedge clk_i) begin
    reply_beat_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) absorb_rx_byte(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: reply beat with none expected: data=%02h last=%0b",
                   $time, m_tdata_i, m_tlast_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = reply_queue.pop_front();
          if (want.data !== m_tdata_i || want.last !== m_tlast_i) begin
            $display("%0t: reply mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                     $time, want.data, want.last, m_tdata_i, m_tlast_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= reply_queue.size();
    end
  end

endmodule

### tb/tb_gain_command_frame_handler.sv
`timescale 1ns / 1ps

module tb_gain_command_frame_handler;
  import gcfh_pkg::*;

  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned SettleCycles = 48;
  localparam int unsigned PartialLen   = 8;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stuck_cycles = 0;

  bit    steady     = 1'b0;
  bit    tx_idle_en = 1'b0;
  bit    rx_idle_en = 1'b0;
  bit    hold_req   = 1'b0;
  byte_t frame_buf [FrameLen];

  gain_command_frame_handler i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  gcfh_reply_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk = ~clk;

  // End the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("gain_command_frame_handler test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: random short stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
        m_tready = 1'b1;
      end else if (!steady && rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one byte, with an optional idle burst first; return after the beat
  task automatic send_beat(input byte_t data, input logic start);
    if (!steady && tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tuser  = start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic mark_start, input int unsigned len);
    for (int i = 0; i < len; i++) send_beat(frame_buf[i], mark_start && i == 0);
  endtask

  // Header and command, random payload
  task automatic prep_frame(input byte_t cmd);
    frame_buf[0] = HdrB0;
    frame_buf[1] = HdrB1;
    frame_buf[2] = HdrB2;
    frame_buf[3] = cmd;
    for (int i = 4; i < FrameLen; i++) frame_buf[i] = byte_t'($urandom);
  endtask

  // Close the frame with its additive sum, spoiled on request
  task automatic seal_frame(input bit corrupt);
    byte_t sum;
    sum = '0;
    for (int i = 0; i < FrameLen - 1; i++) sum = sum + frame_buf[i];
    if (corrupt) sum = sum ^ byte_t'($urandom_range(1, 255));
    frame_buf[FrameLen-1] = sum;
  endtask

  function automatic byte_t other_cmd();
    byte_t cmd;
    do cmd = byte_t'($urandom); while (cmd == CmdLoad || cmd == CmdReply);
    return cmd;
  endfunction

  // Stop offering and hold until every expected reply beat has come
  task automatic drain_replies();
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int unsigned kind;
    int unsigned hdr_idx;
    byte_t       cmd;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Load all-ones payload
    prep_frame(CmdLoad);
    for (int i = 4; i < FrameLen - 1; i++) frame_buf[i] = 8'hFF;
    seal_frame(1'b0);
    send_frame(1'b1, FrameLen);

    // Read it back without a start marker while the receiver holds off
    hold_req = 1'b1;
    prep_frame(CmdReply);
    seal_frame(1'b0);
    send_frame(1'b0, FrameLen);

    // Keep offering a spoiled frame behind the held reply: bad checksum,
    // bad header or unknown command, all ignored
    kind    = $urandom_range(0, 2);
    hdr_idx = $urandom_range(0, 2);
    cmd     = (kind == 2) ? other_cmd() : CmdLoad;
    prep_frame(cmd);
    if (kind == 1) begin
      frame_buf[hdr_idx] = frame_buf[hdr_idx] ^ byte_t'($urandom_range(1, 255));
    end
    seal_frame(kind == 0);
    send_frame(1'b1, FrameLen);
    drain_replies();

    // Start marker mid-frame drops the partial load
    prep_frame(CmdLoad);
    seal_frame(1'b0);
    send_frame(1'b1, PartialLen);

    // Closing stretch without idling on either side
    steady = 1'b1;
    prep_frame(CmdReply);
    seal_frame(1'b0);
    send_frame(1'b1, FrameLen);
    drain_replies();

    if (fail_count == 0) begin
      $display("gain_command_frame_handler test passed");
    end else begin
      $display("gain_command_frame_handler test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/gcfh_pkg.sv
rtl/gcfh_rx.sv
rtl/gain_command_frame_handler.sv
tb/gcfh_reply_checker.sv
tb/tb_gain_command_frame_handler.sv
